// ----- sv/vwd_pkg.sv -----
// ----------------------------------------------------------------------------
// vwd_pkg
// Shared constants for the vertex weld/dedup block: field widths, table
// depth and the fixed-point format of the incoming coordinates.
// ----------------------------------------------------------------------------
package vwd_pkg;

  // incoming coordinates: signed Q16.16 metres
  localparam int unsigned CoordW = 32;
  localparam int unsigned FracW  = 16;

  // grid scale register
  localparam int unsigned ScaleW     = 16;
  localparam int unsigned ScaleReset = 1000;

  // scaled product; |coord * scale| < 2^47 so 48 bits hold it exactly
  localparam int unsigned ProdW = CoordW + ScaleW;

  // a key is the product shifted down by FracW; its magnitude stays below
  // 2^31, so 32 bits hold the same value as a 48 bit sign-extended key
  localparam int unsigned KeyW = ProdW - FracW;

  // one key triple as stored in the key RAM
  localparam int unsigned KeysW = 3 * KeyW;

  // key table
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned IdxW        = $clog2(MaxVertices);
  localparam int unsigned CntW        = IdxW + 1;

  // result index field
  localparam int unsigned OutIdxW = 10;

endpackage

// ----- sv/vwd_ram.sv -----
// ----------------------------------------------------------------------------
// vwd_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vwd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/vwd_quant.sv -----
// ----------------------------------------------------------------------------
// vwd_quant
// Two-stage quantizer shared by all three axes: multiply a Q16.16
// coordinate by the grid scale, then shift down truncating toward zero.
// ----------------------------------------------------------------------------
module vwd_quant (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [vwd_pkg::CoordW-1:0]        coord_i,
  input  logic [vwd_pkg::ScaleW-1:0]        scale_i,
  output logic                              key_valid_o,
  output logic [vwd_pkg::KeyW-1:0]          key_o
);

  logic signed [vwd_pkg::CoordW+vwd_pkg::ScaleW:0] prod_full;
  logic [vwd_pkg::ProdW-1:0] prod_d, prod_q;
  logic                      prod_valid_q;
  logic [vwd_pkg::KeyW-1:0]  key_d, key_q;
  logic                      key_valid_q;
  logic                      round_up;

  // stage 1: signed coordinate times unsigned scale
  assign prod_full = $signed(coord_i) * $signed({1'b0, scale_i});
  assign prod_d    = prod_full[vwd_pkg::ProdW-1:0];

  // stage 2: arithmetic shift floors; negative values with a fraction step
  // back up by one so the result truncates toward zero
  assign round_up = prod_q[vwd_pkg::ProdW-1] & (|prod_q[vwd_pkg::FracW-1:0]);
  assign key_d    = prod_q[vwd_pkg::ProdW-1 -: vwd_pkg::KeyW]
                  + vwd_pkg::KeyW'(round_up);

  // payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    key_q  <= key_d;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      key_valid_q  <= 1'b0;
    end else begin
      prod_valid_q <= in_valid_i;
      key_valid_q  <= prod_valid_q;
    end
  end

  assign key_valid_o = key_valid_q;
  assign key_o       = key_q;

endmodule

// ----- sv/vertex_weld_dedup.sv -----
// ----------------------------------------------------------------------------
// vertex_weld_dedup
// Welds coincident mesh vertices on a quantized grid and returns a
// compacted index per vertex.
// ----------------------------------------------------------------------------
// One vertex request is handled at a time. The three coordinates go one
// after another through a single two-stage multiply/truncate unit, then the
// stored keys are compared one per cycle through the key RAM's single read
// port. A vertex that matches entry i finishes the search on that match; a
// new vertex searches all N stored entries, N being the entry count (up to
// 1024). A vertex holds the input until its result has gone into the output
// register and the block is back in idle, so it also waits for as long as
// its result waits for the output register to free up.
// The result sits in an output register, so a new vertex is taken while the
// previous result still waits downstream. start_of_mesh (tuser) empties the
// table before its vertex is looked up; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module vertex_weld_dedup (
  input  logic        clk_i,
  input  logic        rst_ni,
  // grid_scale register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  // vertex requests
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // x_coord[31:0], y_coord[63:32], z_coord[95:64]
  input  logic        s_axis_tuser,   // start_of_mesh
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // vertex_index[9:0], zero[15:10]
  output logic [1:0]  m_axis_tuser    // is_new[0], table_full[1]
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StQuant  = 4'b0010,
    StSearch = 4'b0100,
    StDone   = 4'b1000
  } vwd_state_e;

  vwd_state_e state_q, state_d;

  logic [vwd_pkg::ScaleW-1:0]   scale_q;
  logic [3*vwd_pkg::CoordW-1:0] coord_q;
  logic [vwd_pkg::KeyW-1:0]     key_q [3];
  logic [vwd_pkg::KeysW-1:0]    key_cat;
  logic [1:0]                   iss_q, iss_d, coll_q, coll_d;
  logic [vwd_pkg::CntW-1:0]     count_q, count_d;
  logic [vwd_pkg::CntW-1:0]     addr_q, addr_d;
  logic [vwd_pkg::IdxW-1:0]     cidx_q, cidx_d;
  logic                         pend_q, pend_d;
  logic                         in_fire;

  // quantizer hookup
  logic                        q_valid;
  logic [vwd_pkg::CoordW-1:0]  q_coord;
  logic                        k_valid;
  logic [vwd_pkg::KeyW-1:0]    k_key;

  // key RAM hookup
  logic                        ram_we, ram_re;
  logic [vwd_pkg::KeysW-1:0]   ram_rdata;
  logic                        hit, miss_done, full;

  // pending result
  logic [vwd_pkg::IdxW-1:0]    res_idx_q, res_idx_d;
  logic                        res_new_q, res_new_d, res_full_q, res_full_d;

  // output register
  logic                        out_valid_q;
  logic [vwd_pkg::OutIdxW-1:0] out_idx_q;
  logic                        out_new_q, out_full_q;
  logic                        out_load;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;

  // grid scale register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= vwd_pkg::ScaleW'(vwd_pkg::ScaleReset);
    end else if (cfg_valid_i) begin
      scale_q <= cfg_data_i;
    end
  end

  // capture coordinates of the accepted vertex
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      coord_q <= s_axis_tdata;
    end
  end

  // feed one axis per cycle to the shared quantizer
  assign q_valid = (state_q == StQuant) && (iss_q != 2'd3);
  always_comb begin
    case (iss_q)
      2'd0:    q_coord = coord_q[vwd_pkg::CoordW-1:0];
      2'd1:    q_coord = coord_q[2*vwd_pkg::CoordW-1:vwd_pkg::CoordW];
      default: q_coord = coord_q[3*vwd_pkg::CoordW-1:2*vwd_pkg::CoordW];
    endcase
  end

  vwd_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .coord_i     (q_coord),
    .scale_i     (scale_q),
    .key_valid_o (k_valid),
    .key_o       (k_key)
  );

  // collect keys as they leave the quantizer
  always_ff @(posedge clk_i) begin
    if (k_valid && (coll_q != 2'd3)) begin
      key_q[coll_q] <= k_key;
    end
  end

  assign key_cat = {key_q[2], key_q[1], key_q[0]};

  // search compare
  assign hit       = (state_q == StSearch) && pend_q && (ram_rdata == key_cat);
  assign miss_done = (state_q == StSearch) && !hit && (addr_q == count_q);
  assign full      = (count_q == vwd_pkg::CntW'(vwd_pkg::MaxVertices));
  assign ram_re    = (state_q == StSearch) && !hit && (addr_q != count_q);
  assign ram_we    = miss_done && !full;

  vwd_ram #(
    .Width (vwd_pkg::KeysW),
    .Depth (vwd_pkg::MaxVertices)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (count_q[vwd_pkg::IdxW-1:0]),
    .wr_data_i (key_cat),
    .rd_en_i   (ram_re),
    .rd_addr_i (addr_q[vwd_pkg::IdxW-1:0]),
    .rd_data_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    coll_d     = coll_q;
    count_d    = count_q;
    addr_d     = addr_q;
    cidx_d     = cidx_q;
    pend_d     = pend_q;
    res_idx_d  = res_idx_q;
    res_new_d  = res_new_q;
    res_full_d = res_full_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = StQuant;
          iss_d   = 2'd0;
          coll_d  = 2'd0;
          if (s_axis_tuser) begin
            count_d = '0;
          end
        end
      end
      StQuant: begin
        if (iss_q != 2'd3) begin
          iss_d = iss_q + 2'd1;
        end
        if (k_valid) begin
          coll_d = coll_q + 2'd1;
          if (coll_q == 2'd2) begin
            state_d = StSearch;
            addr_d  = '0;
            pend_d  = 1'b0;
          end
        end
      end
      StSearch: begin
        pend_d = ram_re;
        if (ram_re) begin
          addr_d = addr_q + vwd_pkg::CntW'(1);
          cidx_d = addr_q[vwd_pkg::IdxW-1:0];
        end
        if (hit) begin
          state_d    = StDone;
          res_idx_d  = cidx_q;
          res_new_d  = 1'b0;
          res_full_d = 1'b0;
        end else if (miss_done) begin
          state_d = StDone;
          if (full) begin
            res_idx_d  = '0;
            res_new_d  = 1'b0;
            res_full_d = 1'b1;
          end else begin
            res_idx_d  = count_q[vwd_pkg::IdxW-1:0];
            res_new_d  = 1'b1;
            res_full_d = 1'b0;
            count_d    = count_q + vwd_pkg::CntW'(1);
          end
        end
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iss_q   <= 2'd0;
      coll_q  <= 2'd0;
      count_q <= '0;
      addr_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_q   <= iss_d;
      coll_q  <= coll_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      pend_q  <= pend_d;
    end
  end

  // search payload registers
  always_ff @(posedge clk_i) begin
    cidx_q     <= cidx_d;
    res_idx_q  <= res_idx_d;
    res_new_q  <= res_new_d;
    res_full_q <= res_full_d;
  end

  // output register, refilled as soon as the previous result is taken
  assign out_load = (state_q == StDone) && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= vwd_pkg::OutIdxW'(res_idx_q);
      out_new_q  <= res_new_q;
      out_full_q <= res_full_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(16 - vwd_pkg::OutIdxW){1'b0}}, out_idx_q};
  assign m_axis_tuser  = {out_full_q, out_new_q};

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vwd_pkg::CntW'(vwd_pkg::MaxVertices))
    else $error("entry count beyond table depth");

  a_store_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + vwd_pkg::CntW'(1))
    else $error("stored key did not advance entry count");

  a_full_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_full_q |-> out_idx_q == '0 && !out_new_q)
    else $error("full result with nonzero index or new flag");

  a_hit_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> vwd_pkg::CntW'(cidx_q) < count_q)
    else $error("match on an entry beyond the entry count");

endmodule
